// ===== design/tsa_pkg.sv =====
`default_nettype none

package tsa_pkg;

  // largest graph the block holds
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned MaskW       = 64;

  localparam logic [CountW-1:0] VertexCountReset = CountW'(MaxVertices);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DRAIN,
    ST_PICK,
    ST_DEC
  } state_e;

  typedef struct packed {
    logic [5:0]       row_index;
    logic [MaskW-1:0] successor_mask;
    logic             last_row;
  } in_item_t;

  typedef struct packed {
    logic [6:0] vertex;
    logic [5:0] position;
    logic       last_result;
    logic       has_cycle;
  } res_item_t;

endpackage

`default_nettype wire

// ===== design/topological_sort_adjacency.sv =====
// operation: a row that is not last is stored and gives no result; the block stays ready
// a last row starts a counting pass that reads one stored row per cycle over the single
//   adjacency read port to count in-degrees, then a drain step, then per placed vertex a pick
//   step and a decrement of its successors; each pick gives one result, n of them, or fewer
//   ending in a cycle flag; busy stays high from the last row to the final result
// reset clears control state, row-written bits, in-degrees and placed bits; vertex_count is 64
`default_nettype none

module topological_sort_adjacency (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // item channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire tsa_pkg::in_item_t     item_i,
  // results, one per strobe, no backpressure
  output logic                       result_strobe_o,
  output tsa_pkg::res_item_t         result_o,
  // vertex_count register write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [6:0]            cfg_data_i
);

  localparam int unsigned MaxV = tsa_pkg::MaxVertices;
  localparam int unsigned AW   = tsa_pkg::AddrW;
  localparam int unsigned CW   = tsa_pkg::CountW;

  // ---------------------------------------------------------------------------
  // configuration register and active vertex count
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   vcount_q;
  logic [CW-1:0]   n_act;
  logic [MaxV-1:0] keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= tsa_pkg::VertexCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vcount_q <= cfg_data_i;
    end
  end

  // zero counts as one, anything above the capacity as the capacity
  always_comb begin
    if (vcount_q == '0) begin
      n_act = CW'(1);
    end else if (vcount_q > CW'(MaxV)) begin
      n_act = CW'(MaxV);
    end else begin
      n_act = vcount_q;
    end
  end

  // vertices and mask bits beyond the active count are ignored
  always_comb begin
    for (int k = 0; k < MaxV; k++) begin
      keep[k] = (CW'(k) < n_act);
    end
  end

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  tsa_pkg::state_e state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;        // row being read in the counting pass
  logic [AW-1:0]   pos_q, pos_d;        // place in the order being filled
  logic [MaxV-1:0] written_q, written_d;
  logic [MaxV-1:0] placed_q, placed_d;
  logic [CW-1:0]   indeg_q [MaxV];
  logic [CW-1:0]   indeg_d [MaxV];
  logic            inc_pend_q, inc_pend_d;   // counting row arrives this cycle
  logic            inc_row_q, inc_row_d;     // that row was written
  logic            dec_row_q, dec_row_d;     // placed vertex has a stored row
  logic            result_strobe_q, result_strobe_d;
  tsa_pkg::res_item_t result_q, result_d;

  logic            accept;
  logic            cnt_last;
  logic            pos_last;
  logic [MaxV-1:0] ready_vec;           // unplaced, in range, in-degree zero
  logic            found;
  logic [AW-1:0]   pick;

  assign busy     = (state_q != tsa_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign cnt_last = ({1'b0, cnt_q} == (n_act - CW'(1)));
  assign pos_last = ({1'b0, pos_q} == (n_act - CW'(1)));

  always_comb begin
    for (int k = 0; k < MaxV; k++) begin
      ready_vec[k] = keep[k] && !placed_q[k] && (indeg_q[k] == '0);
    end
  end

  // lowest-numbered ready vertex
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = MaxV - 1; i >= 0; i--) begin
      if (ready_vec[i]) begin
        found = 1'b1;
        pick  = AW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // adjacency store: one write port for loading, one registered read port
  // shared by the counting pass and the successor decrement
  // ---------------------------------------------------------------------------
  logic [tsa_pkg::MaskW-1:0] adj_mem [MaxV];
  logic [tsa_pkg::MaskW-1:0] rd_data_q;
  logic [AW-1:0]             rd_addr;
  logic                      row_fits;

  assign row_fits = ({1'b0, item_i.row_index} < CW'(MaxV));
  assign rd_addr  = (state_q == tsa_pkg::ST_COUNT) ? cnt_q : pick;

  always_ff @(posedge clk_i) begin
    if (accept && row_fits) begin
      adj_mem[item_i.row_index] <= item_i.successor_mask;
    end
    rd_data_q <= adj_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsa_pkg::ST_IDLE: begin
        if (accept && item_i.last_row) begin
          state_d = tsa_pkg::ST_COUNT;
        end
      end
      tsa_pkg::ST_COUNT: begin
        if (cnt_last) begin
          state_d = tsa_pkg::ST_DRAIN;
        end
      end
      tsa_pkg::ST_DRAIN: begin
        state_d = tsa_pkg::ST_PICK;
      end
      tsa_pkg::ST_PICK: begin
        if (!found || pos_last) begin
          state_d = tsa_pkg::ST_IDLE;
        end else begin
          state_d = tsa_pkg::ST_DEC;
        end
      end
      tsa_pkg::ST_DEC: begin
        state_d = tsa_pkg::ST_PICK;
      end
      default: begin
        state_d = tsa_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_d           = cnt_q;
    pos_d           = pos_q;
    written_d       = written_q;
    placed_d        = placed_q;
    indeg_d         = indeg_q;
    inc_pend_d      = 1'b0;
    inc_row_d       = inc_row_q;
    dec_row_d       = dec_row_q;
    result_strobe_d = 1'b0;
    result_d        = result_q;

    // lane unit: the fetched row bumps the count of every in-range successor at once
    if (inc_pend_q && inc_row_q) begin
      for (int k = 0; k < MaxV; k++) begin
        if (rd_data_q[k] && keep[k]) begin
          indeg_d[k] = indeg_q[k] + CW'(1);
        end
      end
    end

    case (state_q)
      tsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (row_fits) begin
            written_d[item_i.row_index] = 1'b1;
          end
          if (item_i.last_row) begin
            cnt_d    = '0;
            pos_d    = '0;
            placed_d = '0;
            for (int k = 0; k < MaxV; k++) begin
              indeg_d[k] = '0;
            end
          end
        end
      end
      tsa_pkg::ST_COUNT: begin
        // row cnt_q is read now, its data is applied next cycle
        inc_pend_d = 1'b1;
        inc_row_d  = written_q[cnt_q];
        cnt_d      = cnt_q + AW'(1);
      end
      tsa_pkg::ST_DRAIN: begin
      end
      tsa_pkg::ST_PICK: begin
        result_strobe_d = 1'b1;
        result_d.position = pos_q;
        if (!found) begin
          // nothing left with in-degree zero: flag the cycle and stop
          result_d.vertex      = '0;
          result_d.last_result = 1'b1;
          result_d.has_cycle   = 1'b1;
        end else begin
          result_d.vertex      = {1'b0, pick} + 7'd1;
          result_d.last_result = pos_last;
          result_d.has_cycle   = 1'b0;
          placed_d[pick]       = 1'b1;
          dec_row_d            = written_q[pick];
        end
        // end of run: the next rows build a new graph
        if (!found || pos_last) begin
          written_d = '0;
          placed_d  = '0;
          for (int k = 0; k < MaxV; k++) begin
            indeg_d[k] = '0;
          end
        end
      end
      tsa_pkg::ST_DEC: begin
        // successors of the placed vertex lose one incoming edge
        if (dec_row_q) begin
          for (int k = 0; k < MaxV; k++) begin
            if (rd_data_q[k] && keep[k] && (indeg_q[k] != '0)) begin
              indeg_d[k] = indeg_q[k] - CW'(1);
            end
          end
        end
        pos_d = pos_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= tsa_pkg::ST_IDLE;
      cnt_q           <= '0;
      pos_q           <= '0;
      written_q       <= '0;
      placed_q        <= '0;
      inc_pend_q      <= 1'b0;
      inc_row_q       <= 1'b0;
      dec_row_q       <= 1'b0;
      result_strobe_q <= 1'b0;
      for (int k = 0; k < MaxV; k++) begin
        indeg_q[k] <= '0;
      end
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      pos_q           <= pos_d;
      written_q       <= written_d;
      placed_q        <= placed_d;
      inc_pend_q      <= inc_pend_d;
      inc_row_q       <= inc_row_d;
      dec_row_q       <= dec_row_d;
      result_strobe_q <= result_strobe_d;
      indeg_q         <= indeg_d;
    end
  end

  // result word needs no reset
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_strobe_o = result_strobe_q;
  assign result_o        = result_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result word only ever comes out of a pick step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == tsa_pkg::ST_PICK))
    else $error("result word without a pick step");

  // a cycle flag ends the run and carries no vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.has_cycle) |->
      (result_o.last_result && (result_o.vertex == '0)))
    else $error("cycle flag malformed");

  // the final word of a run leaves the block idle with a clean graph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last_result) |->
      (!busy && (written_q == '0) && (placed_q == '0)))
    else $error("run state not cleared after final word");

  // counting pass never overlaps a decrement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_pend_q |-> (state_q == tsa_pkg::ST_COUNT || state_q == tsa_pkg::ST_DRAIN))
    else $error("in-degree count applied outside counting pass");

endmodule

`default_nettype wire

// ===== bench/tb_topological_sort_adjacency.sv =====
`timescale 1ns / 1ps

module tb_topological_sort_adjacency;

  // least number of random rows after the directed table
  localparam int RandWords    = 252;
  // cycles to let pass after the last placement before touching vertex_count
  localparam int SettleCycles = 4;
  // generous bound: every row as if it started a full 64-vertex run, plus gaps
  localparam int CycleLimit   = 400000;
  localparam int DirN         = 18;

  // one row of the directed table: optional vertex_count write ahead of the word,
  // the word itself, and a hand-typed placement where it is obvious
  typedef struct packed {
    logic                set_cnt;
    logic [6:0]          cnt;
    tsa_pkg::in_item_t   word;
    logic                typed;
    tsa_pkg::res_item_t  want;
  } dir_row_t;

  localparam tsa_pkg::res_item_t NoRes = '0;

  localparam dir_row_t DirTab [DirN] = '{
    // reset count of 64, no edges: vertices 1..64 in order
    '{1'b0, 7'd0,   '{6'd0,  64'd0, 1'b1}, 1'b0, NoRes},
    // single vertex, no edge: one placement, last
    '{1'b1, 7'd1,   '{6'd0,  64'd0, 1'b1}, 1'b1, '{7'd1, 6'd0, 1'b1, 1'b0}},
    // single vertex with a self loop: cycle at the first place
    '{1'b0, 7'd0,   '{6'd0,  64'h1, 1'b1}, 1'b1, '{7'd0, 6'd0, 1'b1, 1'b1}},
    // count 0 acts as 1, row above the count ignored
    '{1'b1, 7'd0,   '{6'd5,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1,
      '{7'd1, 6'd0, 1'b1, 1'b0}},
    // count 127 acts as 64, top vertex points at all others
    '{1'b1, 7'd127, '{6'd63, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd0,  64'd0, 1'b1}, 1'b0, NoRes},
    // full row including a self loop: nothing ever reaches in-degree zero
    '{1'b1, 7'd64,  '{6'd10, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1,
      '{7'd0, 6'd0, 1'b1, 1'b1}},
    // loop through vertices 0, 2 and 1 whose closing row is then overwritten: chain 3, 2, 1
    '{1'b1, 7'd3,   '{6'd0,  64'h4, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd2,  64'h2, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd1,  64'h1, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd0,  64'h0, 1'b1}, 1'b0, NoRes},
    // loop of vertices 0 and 1 plus one free vertex: one placement, then the cycle flag
    '{1'b0, 7'd0,   '{6'd0,  64'h2, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd1,  64'h1, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd2,  64'h1, 1'b1}, 1'b0, NoRes},
    // out-of-range row and mask bits above the count
    '{1'b1, 7'd4,   '{6'd40, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd3,  64'hFFFF_FFFF_FFFF_FFF1, 1'b0}, 1'b0, NoRes},
    '{1'b0, 7'd0,   '{6'd1,  64'h4, 1'b1}, 1'b0, NoRes},
    // vertex 0 never written counts as edgeless
    '{1'b1, 7'd2,   '{6'd1,  64'h1, 1'b1}, 1'b0, NoRes}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  tsa_pkg::in_item_t   item_i      = '0;
  logic                result_strobe_o;
  tsa_pkg::res_item_t  result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [6:0]          cfg_data_i  = '0;

  // shadow of the graph store and the vertex_count register
  logic [63:0] adj_rows [tsa_pkg::MaxVertices];
  logic [63:0] row_seen  = '0;
  logic [6:0]  vtx_count = tsa_pkg::VertexCountReset;

  // placements still owed by the block, oldest first
  tsa_pkg::res_item_t order_due [$];
  // placements worked out for the word just accepted
  tsa_pkg::res_item_t fresh [$];

  int  errors     = 0;
  int  checked    = 0;
  int  words_sent = 0;
  int  graphs     = 0;
  int  cycle_runs = 0;
  int  cfg_writes = 0;
  int  cycles     = 0;
  bit  calm       = 1'b0;

  topological_sort_adjacency dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // store the row; on the last row count in-degrees and place vertices by kahn's rule
  function automatic void kahn_order(tsa_pkg::in_item_t w);
    int                  n;
    int                  v;
    int                  k;
    int                  pos;
    int                  pick;
    int                  indeg [tsa_pkg::MaxVertices];
    logic [63:0]         keep;
    logic [63:0]         succ;
    logic [63:0]         done;
    tsa_pkg::res_item_t  r;
    fresh.delete();
    adj_rows[w.row_index] = w.successor_mask;
    row_seen[w.row_index] = 1'b1;
    if (!w.last_row) return;
    // out-of-range counts clamp to 1..64
    n = int'(vtx_count);
    if (n < 1) n = 1;
    if (n > int'(tsa_pkg::MaxVertices)) n = int'(tsa_pkg::MaxVertices);
    keep = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (v = 0; v < int'(tsa_pkg::MaxVertices); v++) indeg[v] = 0;
    for (v = 0; v < n; v++) begin
      if (row_seen[v]) begin
        succ = adj_rows[v] & keep;
        for (k = 0; k < n; k++) if (succ[k]) indeg[k]++;
      end
    end
    done = '0;
    for (pos = 0; pos < n; pos++) begin
      pick = n;
      for (v = 0; v < n; v++) begin
        if (!done[v] && indeg[v] == 0) begin
          pick = v;
          break;
        end
      end
      if (pick == n) begin
        // nothing free: one flag word closes the run
        r.vertex      = '0;
        r.position    = 6'(pos);
        r.last_result = 1'b1;
        r.has_cycle   = 1'b1;
        fresh.push_back(r);
        break;
      end
      r.vertex      = 7'(pick + 1);
      r.position    = 6'(pos);
      r.last_result = (pos + 1 == n);
      r.has_cycle   = 1'b0;
      fresh.push_back(r);
      done[pick] = 1'b1;
      if (row_seen[pick]) begin
        succ = adj_rows[pick] & keep;
        for (k = 0; k < n; k++) if (succ[k] && indeg[k] > 0) indeg[k]--;
      end
    end
    // next rows start a new graph
    row_seen = '0;
  endfunction

  function automatic logic [63:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  // random idle cycles on the sending side, none during the calm stretch
  task automatic sender_gap();
    if (calm) return;
    while ($urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // hold the word until the block takes it, then book its placements
  task automatic send_word(tsa_pkg::in_item_t w, logic typed, tsa_pkg::res_item_t want);
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    kahn_order(w);
    if (typed) begin
      order_due.push_back(want);
    end else begin
      foreach (fresh[i]) order_due.push_back(fresh[i]);
    end
    if (w.last_row) begin
      graphs++;
      if (fresh.size() != 0 && fresh[fresh.size() - 1].has_cycle) cycle_runs++;
    end
    words_sent++;
  endtask

  // stop sending until every placement is in and the block has settled
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (order_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vtx_count = val;
    cfg_writes++;
  endtask

  // one graph: mostly dags in a shuffled vertex order, some with random edges
  // (usually cyclic), some with junk rows, stray high mask bits and skipped rows
  task automatic random_graph();
    int                 n;
    int                 i;
    int                 j;
    int                 k;
    int                 v;
    int                 tmp;
    int                 dens;
    int                 perm [64];
    int                 rank [64];
    bit                 acyclic;
    bit                 noisy;
    logic [6:0]         raw;
    logic [63:0]        keep;
    logic [63:0]        m;
    tsa_pkg::in_item_t  w;
    tsa_pkg::in_item_t  rows [$];
    if ($urandom_range(0, 99) < 55) begin
      tmp = $urandom_range(0, 99);
      if (tmp < 75)      n = $urandom_range(1, 6);
      else if (tmp < 95) n = $urandom_range(7, 16);
      else if (tmp < 98) n = $urandom_range(17, 63);
      else               n = 64;
      raw = 7'(n);
      if (n == 1 && $urandom_range(0, 2) == 0) raw = 7'd0;
      if (n == 64 && $urandom_range(0, 1) == 0) raw = 7'($urandom_range(65, 127));
      write_count(raw);
    end
    n = int'(vtx_count);
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    keep    = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    acyclic = ($urandom_range(0, 99) < 75);
    noisy   = ($urandom_range(0, 99) < 30);
    dens    = $urandom_range(0, 60);
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (i = 0; i < n; i++) rank[perm[i]] = i;
    // reshuffle so the row order is unrelated to the topological order
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (i = 0; i < n; i++) begin
      v = perm[i];
      if ($urandom_range(0, 99) < 10) continue;
      m = '0;
      for (k = 0; k < n; k++)
        if ((!acyclic || rank[k] > rank[v]) && $urandom_range(0, 99) < dens) m[k] = 1'b1;
      if (noisy) m |= rand_mask() & ~keep;
      // junk first, the real row replaces it
      if (noisy && $urandom_range(0, 99) < 20) rows.push_back('{6'(v), rand_mask(), 1'b0});
      rows.push_back('{6'(v), m, 1'b0});
      if (noisy && n < 64 && $urandom_range(0, 99) < 20)
        rows.push_back('{6'($urandom_range(n, 63)), rand_mask(), 1'b0});
    end
    if (rows.size() == 0) rows.push_back('{6'($urandom_range(0, n - 1)), 64'd0, 1'b0});
    w = rows.pop_back();
    w.last_row = 1'b1;
    rows.push_back(w);
    foreach (rows[i]) begin
      sender_gap();
      send_word(rows[i], 1'b0, NoRes);
    end
  endtask

  task automatic flag_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // every strobe is matched against the oldest owed placement
  always @(posedge clk_i) begin
    tsa_pkg::res_item_t exp_r;
    cycles = cycles + 1;
    if (rst_ni && result_strobe_o) begin
      if (order_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual vertex %0d position %0d",
                 $time, result_o.vertex, result_o.position);
      end else begin
        exp_r = order_due.pop_front();
        checked++;
        flag_field("vertex",      exp_r.vertex,      result_o.vertex);
        flag_field("position",    exp_r.position,    result_o.position);
        flag_field("last_result", exp_r.last_result, result_o.last_result);
        flag_field("has_cycle",   exp_r.has_cycle,   result_o.has_cycle);
      end
    end
  end

  // runaway guard
  initial begin
    wait (cycles >= CycleLimit);
    $display("topological_sort_adjacency test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirTab[i]) begin
      if (DirTab[i].set_cnt) write_count(DirTab[i].cnt);
      sender_gap();
      send_word(DirTab[i].word, DirTab[i].typed, DirTab[i].want);
    end

    // random graphs, with a stretch of back-to-back rows in the middle
    while (words_sent < DirN + RandWords) begin
      calm = (graphs >= 14 && graphs < 26);
      random_graph();
    end
    calm = 1'b0;

    drain_results();
    repeat (16) @(posedge clk_i);

    $display("sent %0d rows forming %0d graphs (%0d ended in a cycle), %0d vertex_count writes",
             words_sent, graphs, cycle_runs, cfg_writes);
    $display("checked %0d placement words, %0d mismatches", checked, errors);
    if (errors == 0 && order_due.size() == 0) begin
      $display("topological_sort_adjacency test passed");
    end else begin
      $display("topological_sort_adjacency test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tsa_pkg.sv
design/topological_sort_adjacency.sv
bench/tb_topological_sort_adjacency.sv
